FILE: src/khbi_pkg.sv
package khbi_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned MASK_W = 31;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned UPC_W = 5;
  localparam int unsigned FMIX_SHIFT = 33;

  localparam logic [WORD_W-1:0] MUL_WORD = 64'h517c_c1b7_2722_0a95;
  localparam logic [WORD_W-1:0] FMIX_K1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [WORD_W-1:0] FMIX_K2 = 64'hc4ce_b9fe_1a85_ec53;

  localparam logic [CNT_W-1:0] CNT_FULL = 4'd8;
  localparam logic [CNT_W-1:0] CNT_TAIL32 = 4'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_MASK = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_EXTEND = 1'b1;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_ACCEPT,
    COND_FULL,
    COND_TAIL_SHORT,
    COND_NOT_LAST,
    COND_POS_DONE,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_op_t;

  typedef enum logic [1:0] {
    K_MUL_WORD,
    K_FMIX1,
    K_FMIX2
  } k_sel_t;

  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    H_KEEP,
    H_ABSORB,
    H_MIX,
    H_OUT
  } h_op_t;

  typedef enum logic [2:0] {
    V_KEEP,
    V_WORD,
    V_TAIL32,
    V_BYTE,
    V_ZERO
  } v_sel_t;

  typedef enum logic [1:0] {
    POS_KEEP,
    POS_FULL,
    POS_TAIL,
    POS_INC
  } pos_op_t;

  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    mul_op_t          mul_op;
    k_sel_t           k_sel;
    acc_op_t          acc_op;
    h_op_t            h_op;
    v_sel_t           v_sel;
    pos_op_t          pos_op;
  } ctl_word_t;

  typedef struct packed {
    logic accept;
    logic full;
    logic tail_short;
    logic not_last;
    logic pos_done;
    logic out_busy;
  } status_t;

endpackage

FILE: src/khbi_useq.sv
module khbi_useq (
  input  logic                clk,
  input  logic                rst,
  input  khbi_pkg::status_t   status,
  output khbi_pkg::ctl_word_t ctl,
  output logic                idle
);
  import khbi_pkg::*;

  localparam logic [UPC_W-1:0] UA_WAIT = 5'd0;
  localparam logic [UPC_W-1:0] UA_SEL = 5'd1;
  localparam logic [UPC_W-1:0] UA_TAIL = 5'd2;
  localparam logic [UPC_W-1:0] UA_ABSORB = 5'd3;
  localparam logic [UPC_W-1:0] UA_BCHK = 5'd8;
  localparam logic [UPC_W-1:0] UA_BYTE = 5'd9;
  localparam logic [UPC_W-1:0] UA_FIN = 5'd10;
  localparam logic [UPC_W-1:0] UA_OUT = 5'd23;
  localparam logic [UPC_W-1:0] UA_LAST = 5'd23;

  logic [UPC_W-1:0] pc;
  logic [UPC_W-1:0] pc_next;
  logic             cond_true;

  function automatic ctl_word_t uw(cond_t c, logic [UPC_W-1:0] t, mul_op_t m, k_sel_t k,
                                   acc_op_t a, h_op_t h, v_sel_t v, pos_op_t p);
    ctl_word_t w;
    w.cond = c;
    w.target = t;
    w.mul_op = m;
    w.k_sel = k;
    w.acc_op = a;
    w.h_op = h;
    w.v_sel = v;
    w.pos_op = p;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      5'd0:  ctl = uw(COND_NOT_ACCEPT, UA_WAIT, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd1:  ctl = uw(COND_FULL, UA_ABSORB, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_KEEP,
                      V_WORD, POS_FULL);
      5'd2:  ctl = uw(COND_TAIL_SHORT, UA_BCHK, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_KEEP,
                      V_TAIL32, POS_TAIL);
      5'd3:  ctl = uw(COND_NEVER, UA_WAIT, MUL_LL, K_MUL_WORD, ACC_KEEP, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd4:  ctl = uw(COND_NEVER, UA_WAIT, MUL_LH, K_MUL_WORD, ACC_LOAD, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd5:  ctl = uw(COND_NEVER, UA_WAIT, MUL_HL, K_MUL_WORD, ACC_ADD_HI, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd6:  ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_MUL_WORD, ACC_ADD_HI, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd7:  ctl = uw(COND_NOT_LAST, UA_WAIT, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_ABSORB,
                      V_KEEP, POS_KEEP);
      5'd8:  ctl = uw(COND_POS_DONE, UA_FIN, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd9:  ctl = uw(COND_ALWAYS, UA_ABSORB, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_KEEP,
                      V_BYTE, POS_INC);
      5'd10: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX1, ACC_KEEP, H_MIX,
                      V_ZERO, POS_KEEP);
      5'd11: ctl = uw(COND_NEVER, UA_WAIT, MUL_LL, K_FMIX1, ACC_KEEP, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd12: ctl = uw(COND_NEVER, UA_WAIT, MUL_LH, K_FMIX1, ACC_LOAD, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd13: ctl = uw(COND_NEVER, UA_WAIT, MUL_HL, K_FMIX1, ACC_ADD_HI, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd14: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX1, ACC_ADD_HI, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd15: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX1, ACC_KEEP, H_ABSORB,
                      V_KEEP, POS_KEEP);
      5'd16: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX2, ACC_KEEP, H_MIX,
                      V_KEEP, POS_KEEP);
      5'd17: ctl = uw(COND_NEVER, UA_WAIT, MUL_LL, K_FMIX2, ACC_KEEP, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd18: ctl = uw(COND_NEVER, UA_WAIT, MUL_LH, K_FMIX2, ACC_LOAD, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd19: ctl = uw(COND_NEVER, UA_WAIT, MUL_HL, K_FMIX2, ACC_ADD_HI, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd20: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX2, ACC_ADD_HI, H_KEEP,
                      V_KEEP, POS_KEEP);
      5'd21: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX2, ACC_KEEP, H_ABSORB,
                      V_KEEP, POS_KEEP);
      5'd22: ctl = uw(COND_NEVER, UA_WAIT, MUL_NONE, K_FMIX2, ACC_KEEP, H_MIX,
                      V_KEEP, POS_KEEP);
      5'd23: ctl = uw(COND_OUT_BUSY, UA_OUT, MUL_NONE, K_FMIX2, ACC_KEEP, H_OUT,
                      V_KEEP, POS_KEEP);
      default: ctl = uw(COND_ALWAYS, UA_WAIT, MUL_NONE, K_MUL_WORD, ACC_KEEP, H_KEEP,
                        V_KEEP, POS_KEEP);
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:      cond_true = 1'b0;
      COND_ALWAYS:     cond_true = 1'b1;
      COND_NOT_ACCEPT: cond_true = !status.accept;
      COND_FULL:       cond_true = status.full;
      COND_TAIL_SHORT: cond_true = status.tail_short;
      COND_NOT_LAST:   cond_true = status.not_last;
      COND_POS_DONE:   cond_true = status.pos_done;
      COND_OUT_BUSY:   cond_true = status.out_busy;
      default:         cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_next = ctl.target;
    end else if (pc == UA_LAST) begin
      pc_next = UA_WAIT;
    end else begin
      pc_next = pc + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UA_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign idle = (pc == UA_WAIT);

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (pc == UA_WAIT && status.accept) |=> (pc == UA_SEL))
    else $error("accepted beat did not start the program");

  a_out_returns: assert property (@(posedge clk) disable iff (rst)
    (pc == UA_OUT && !status.out_busy) |=> (pc == UA_WAIT))
    else $error("result step did not return to the wait step");

  a_byte_loops: assert property (@(posedge clk) disable iff (rst)
    (pc == UA_BYTE) |=> (pc == UA_ABSORB))
    else $error("byte step did not enter the multiply sequence");

  a_tail_short: assert property (@(posedge clk) disable iff (rst)
    (pc == UA_TAIL && status.tail_short) |=> (pc == UA_BCHK))
    else $error("short tail did not go to the byte check");

endmodule

FILE: src/khbi_dp.sv
module khbi_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  khbi_pkg::ctl_word_t                  ctl,
  input  logic                                 accept,
  input  logic [khbi_pkg::WORD_W-1:0]          key_word,
  input  logic [khbi_pkg::CNT_W-1:0]           byte_count,
  input  logic                                 last_chunk,
  input  logic                                 cfg_we,
  input  logic [khbi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [khbi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 out_stall,
  output khbi_pkg::status_t                    status,
  output logic                                 out_valid,
  output logic [khbi_pkg::WORD_W-1:0]          key_hash,
  output logic [khbi_pkg::MASK_W-1:0]          bucket_index
);
  import khbi_pkg::*;

  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  cnt;
  logic              last;
  logic [CNT_W-1:0]  pos;
  logic [WORD_W-1:0] v;
  logic [WORD_W-1:0] h;
  logic [WORD_W-1:0] p;
  logic [WORD_W-1:0] acc;
  logic [MASK_W-1:0] bucket_mask;
  logic              zero_extend_short;

  logic [WORD_W-1:0] k_full;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_k;
  logic [WORD_W-1:0] prod;
  logic [7:0]        tail_byte;
  logic [WORD_W-1:0] v_next;
  logic [CNT_W-1:0]  pos_next;
  logic              out_free;
  logic              out_load;

  always_comb begin
    unique case (ctl.k_sel)
      K_MUL_WORD: k_full = MUL_WORD;
      K_FMIX1:    k_full = FMIX_K1;
      K_FMIX2:    k_full = FMIX_K2;
      default:    k_full = MUL_WORD;
    endcase
  end

  always_comb begin
    unique case (ctl.mul_op)
      MUL_LH: begin
        mul_a = h[HALF_W-1:0];
        mul_k = k_full[WORD_W-1:HALF_W];
      end
      MUL_HL: begin
        mul_a = h[WORD_W-1:HALF_W];
        mul_k = k_full[HALF_W-1:0];
      end
      default: begin
        mul_a = h[HALF_W-1:0];
        mul_k = k_full[HALF_W-1:0];
      end
    endcase
  end

  assign prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_k};

  assign tail_byte = word[{pos[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (ctl.v_sel)
      V_WORD:   v_next = word;
      V_TAIL32: v_next = {{HALF_W{word[HALF_W-1] & ~zero_extend_short}}, word[HALF_W-1:0]};
      V_BYTE:   v_next = {{(WORD_W-8){tail_byte[7]}}, tail_byte};
      V_ZERO:   v_next = '0;
      default:  v_next = v;
    endcase
  end

  always_comb begin
    unique case (ctl.pos_op)
      POS_FULL: pos_next = CNT_FULL;
      POS_TAIL: pos_next = (cnt >= CNT_TAIL32) ? CNT_TAIL32 : '0;
      POS_INC:  pos_next = pos + 4'd1;
      default:  pos_next = pos;
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  assign out_load = (ctl.h_op == H_OUT) && out_free;

  assign status.accept = accept;
  assign status.full = !last || (cnt == CNT_FULL);
  assign status.tail_short = (cnt < CNT_TAIL32);
  assign status.not_last = !last;
  assign status.pos_done = (pos >= cnt);
  assign status.out_busy = !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
      out_valid <= 1'b0;
      bucket_mask <= '0;
      zero_extend_short <= 1'b0;
      cnt <= '0;
      pos <= '0;
      last <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BUCKET_MASK: bucket_mask <= cfg_data[MASK_W-1:0];
          REG_ZERO_EXTEND: zero_extend_short <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        cnt <= (byte_count > CNT_FULL) ? CNT_FULL : byte_count;
        last <= last_chunk;
      end
      pos <= pos_next;
      unique case (ctl.h_op)
        H_ABSORB: h <= acc + v;
        H_MIX:    h <= h ^ (h >> FMIX_SHIFT);
        H_OUT:    if (out_free) h <= '0;
        default:  ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= key_word;
    end
    v <= v_next;
    if (ctl.mul_op != MUL_NONE) begin
      p <= prod;
    end
    case (ctl.acc_op)
      ACC_LOAD:   acc <= p;
      ACC_ADD_HI: acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + p[HALF_W-1:0];
      default:    ;
    endcase
    if (out_load) begin
      key_hash <= h;
      bucket_index <= h[MASK_W-1:0] & bucket_mask;
    end
  end

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && h == '0 && key_hash == $past(h)))
    else $error("result load did not clear the running hash");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos <= CNT_FULL) && (cnt <= CNT_FULL))
    else $error("byte position or count beyond eight");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(key_hash)))
    else $error("stalled result was overwritten");

endmodule

FILE: src/key_hash_bucket_index.sv
// Hashes a key that arrives as a sequence of input beats of up to eight
// little-endian bytes. Every beat but the last is absorbed as a full word;
// the last beat carries 0 to 8 valid bytes in byte_count, and its result
// beat carries the finalised 64-bit hash and its bucket index.
// The input channel takes a beat only while the microprogram waits at its
// first step; in_stall is high otherwise. Each 64-bit multiply is done by
// one shared 32x32 multiplier in four steps plus a write-back step, so a
// beat is accepted only after the previous beat is done; among last beats
// an empty one is fastest and one with seven bytes the slowest before the
// block is ready again.
// The result sits in an output register; if the receiver stalls, the block
// holds at its final step until the register is free, and the running hash
// stays untouched until then.
// A synchronous reset returns the program to its wait step, clears the
// running hash, the result valid flag and both configuration registers.
// Configuration writes are taken at any cycle but belong in idle periods.
module key_hash_bucket_index (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [khbi_pkg::WORD_W-1:0]          key_word,
  input  logic [khbi_pkg::CNT_W-1:0]           byte_count,
  input  logic                                 last_chunk,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [khbi_pkg::WORD_W-1:0]          key_hash,
  output logic [khbi_pkg::MASK_W-1:0]          bucket_index,
  input  logic                                 cfg_we,
  input  logic [khbi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [khbi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import khbi_pkg::*;

  ctl_word_t ctl;
  status_t   status;
  logic      idle;
  logic      accept;

  assign in_stall = !idle;
  assign accept = in_valid && idle;

  khbi_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl),
    .idle   (idle)
  );

  khbi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .accept       (accept),
    .key_word     (key_word),
    .byte_count   (byte_count),
    .last_chunk   (last_chunk),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .status       (status),
    .out_valid    (out_valid),
    .key_hash     (key_hash),
    .bucket_index (bucket_index)
  );

endmodule
